>>> src/delay_timer_heap_scheduler_macros.svh
// assertion macros for the delay timer heap scheduler
// used by the top level only; expects clk and rst_n in scope
`ifndef DELAY_TIMER_HEAP_SCHEDULER_MACROS_SVH
`define DELAY_TIMER_HEAP_SCHEDULER_MACROS_SVH

// same-cycle implication
`define DTHS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DTHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/dths_pkg.sv
// shared types and constants of the delay timer heap scheduler
// no dependencies
package dths_pkg;

  localparam int HEAP_DEPTH  = 8;
  localparam int HANDLE_BITS = 8;
  localparam int TICK_W      = 32;
  localparam int ADDR_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W       = $clog2(HEAP_DEPTH + 1);
  localparam int CHILD_W     = ADDR_W + 2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ACCEPT  = 2'd0;
  localparam kind_t KIND_REJECT  = 2'd1;
  localparam kind_t KIND_EXPIRED = 2'd2;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_SCHED = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0]      expiry;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [TICK_W-1:0] tick;
    logic              pend_v;
  } ctrl_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_CMP,
    ST_TK_CHECK,
    ST_TK_ROOT,
    ST_POP_LAST,
    ST_DN_START,
    ST_DN_L,
    ST_DN_R,
    ST_DN_CMP
  } state_t;

endpackage

>>> src/dths_ram.sv
// heap entry store: one write port, one registered read port
// depends on dths_pkg
module dths_ram (
  input  logic              clk,
  input  dths_pkg::ram_req_t req,
  output dths_pkg::entry_t   rdata
);

  dths_pkg::entry_t mem [dths_pkg::HEAP_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

>>> src/dths_ctrl.sv
// sequencer: tick counter, entry count, sift-up and sift-down over the heap store
// depends on dths_pkg
module dths_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_op,
  input  logic [dths_pkg::TICK_W-1:0]       in_delay,
  input  logic [dths_pkg::HANDLE_BITS-1:0]  in_handle,
  output logic                              out_valid,
  output logic [1:0]                        out_kind,
  output logic [dths_pkg::HANDLE_BITS-1:0]  out_fired_handle,
  output logic [dths_pkg::TICK_W-1:0]       out_tick_now,
  output logic                              out_last,
  output dths_pkg::ram_req_t                ram_req,
  input  dths_pkg::entry_t                  ram_rdata,
  output dths_pkg::ctrl_stat_t              stat
);

  localparam int AW = dths_pkg::ADDR_W;
  localparam int CW = dths_pkg::CHILD_W;
  localparam int NW = dths_pkg::CNT_W;
  localparam int TW = dths_pkg::TICK_W;
  localparam int HW = dths_pkg::HANDLE_BITS;

  dths_pkg::state_t state_r, state_nxt;
  logic [TW-1:0]  tick_r, tick_nxt;
  logic [NW-1:0]  count_r, count_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [TW-1:0]  dly_r, dly_nxt;
  dths_pkg::entry_t new_r, new_nxt;
  dths_pkg::entry_t me_r, me_nxt;
  dths_pkg::entry_t left_r, left_nxt;
  dths_pkg::entry_t ch_r, ch_nxt;
  logic [AW-1:0]  chidx_r, chidx_nxt;
  logic           pend_v_r, pend_v_nxt;
  logic [HW-1:0]  pend_h_r, pend_h_nxt;
  logic           ov_r, ov_nxt;
  logic [1:0]     ok_r, ok_nxt;
  logic [HW-1:0]  oh_r, oh_nxt;
  logic [TW-1:0]  ot_r, ot_nxt;
  logic           ol_r, ol_nxt;
  logic           up_root_fix_r;
  dths_pkg::ram_req_t req_c;
  dths_pkg::ram_req_t req_out;

  // shared decisions
  logic           accept, full, reject, up_less, root_hit, l_ok, r_ok, pick_l, down_move;
  logic [AW-1:0]  parent;
  logic [CW-1:0]  l_w, r_w, c_w;
  logic [NW-1:0]  cnt_dec;

  always_comb begin
    accept    = start && (state_r == dths_pkg::ST_IDLE) && !up_root_fix_r;
    full      = (count_r == NW'(dths_pkg::HEAP_DEPTH));
    reject    = full || (in_delay == '0);
    parent    = AW'((idx_r - AW'(1)) >> 1);
    up_less   = dly_r < (ram_rdata.expiry - tick_r);
    root_hit  = (ram_rdata.expiry == tick_r);
    l_w       = CW'({idx_r, 1'b1});
    r_w       = l_w + CW'(1);
    c_w       = CW'(count_r);
    l_ok      = l_w < c_w;
    r_ok      = r_w < c_w;
    pick_l    = (left_r.expiry - tick_r) < (ram_rdata.expiry - tick_r);
    down_move = (ch_r.expiry - tick_r) < (me_r.expiry - tick_r);
    cnt_dec   = count_r - NW'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dths_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op == dths_pkg::OP_SCHED) begin
            if (!reject && count_r != '0) state_nxt = dths_pkg::ST_UP_CMP;
          end else if (count_r != '0) begin
            state_nxt = dths_pkg::ST_TK_ROOT;
          end
        end
      end
      dths_pkg::ST_UP_CMP: begin
        if (!up_less || parent == '0) state_nxt = dths_pkg::ST_IDLE;
      end
      dths_pkg::ST_TK_CHECK: begin
        state_nxt = (count_r == '0) ? dths_pkg::ST_IDLE : dths_pkg::ST_TK_ROOT;
      end
      dths_pkg::ST_TK_ROOT: begin
        state_nxt = root_hit ? dths_pkg::ST_POP_LAST : dths_pkg::ST_IDLE;
      end
      dths_pkg::ST_POP_LAST: state_nxt = dths_pkg::ST_DN_START;
      dths_pkg::ST_DN_START: begin
        state_nxt = l_ok ? dths_pkg::ST_DN_L : dths_pkg::ST_TK_CHECK;
      end
      dths_pkg::ST_DN_L: state_nxt = r_ok ? dths_pkg::ST_DN_R : dths_pkg::ST_DN_CMP;
      dths_pkg::ST_DN_R: state_nxt = dths_pkg::ST_DN_CMP;
      dths_pkg::ST_DN_CMP: begin
        state_nxt = down_move ? dths_pkg::ST_DN_START : dths_pkg::ST_TK_CHECK;
      end
      default: state_nxt = dths_pkg::ST_IDLE;
    endcase
  end

  // datapath, store requests and result beats
  always_comb begin
    tick_nxt   = tick_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    dly_nxt    = dly_r;
    new_nxt    = new_r;
    me_nxt     = me_r;
    left_nxt   = left_r;
    ch_nxt     = ch_r;
    chidx_nxt  = chidx_r;
    pend_v_nxt = pend_v_r;
    pend_h_nxt = pend_h_r;
    ov_nxt     = 1'b0;
    ok_nxt     = ok_r;
    oh_nxt     = oh_r;
    ot_nxt     = ot_r;
    ol_nxt     = ol_r;
    req_c      = '0;
    case (state_r)
      dths_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_op == dths_pkg::OP_SCHED) begin
            ov_nxt = 1'b1;
            oh_nxt = in_handle;
            ot_nxt = tick_r;
            ol_nxt = 1'b1;
            ok_nxt = reject ? dths_pkg::KIND_REJECT : dths_pkg::KIND_ACCEPT;
            if (!reject) begin
              new_nxt.expiry = tick_r + in_delay;
              new_nxt.handle = in_handle;
              dly_nxt        = in_delay;
              idx_nxt        = count_r[AW-1:0];
              count_nxt      = count_r + NW'(1);
              if (count_r == '0) begin
                req_c.we    = 1'b1;
                req_c.waddr = '0;
                req_c.wdata = new_nxt;
              end else begin
                req_c.raddr = AW'((count_r[AW-1:0] - AW'(1)) >> 1);
              end
            end
          end else begin
            tick_nxt    = tick_r + TW'(1);
            pend_v_nxt  = 1'b0;
            req_c.raddr = '0;
          end
        end
      end
      // sift-up: parent data is on the read port
      dths_pkg::ST_UP_CMP: begin
        req_c.we = 1'b1;
        if (up_less) begin
          req_c.waddr = idx_r;
          req_c.wdata = ram_rdata;
          idx_nxt     = parent;
          req_c.raddr = AW'((parent - AW'(1)) >> 1);
          if (parent == '0) begin
            // new entry becomes root; the root slot is written through up_root_fix_r
            req_c.waddr = idx_r;
          end
        end else begin
          req_c.waddr = idx_r;
          req_c.wdata = new_r;
        end
      end
      // root check after a pop
      dths_pkg::ST_TK_CHECK: begin
        req_c.raddr = '0;
        if (count_r == '0) begin
          ov_nxt     = 1'b1;
          ok_nxt     = dths_pkg::KIND_EXPIRED;
          oh_nxt     = pend_h_r;
          ot_nxt     = tick_r;
          ol_nxt     = 1'b1;
          pend_v_nxt = 1'b0;
        end
      end
      dths_pkg::ST_TK_ROOT: begin
        if (pend_v_r) begin
          ov_nxt = 1'b1;
          ok_nxt = dths_pkg::KIND_EXPIRED;
          oh_nxt = pend_h_r;
          ot_nxt = tick_r;
          ol_nxt = !root_hit;
        end
        if (root_hit) begin
          pend_v_nxt  = 1'b1;
          pend_h_nxt  = ram_rdata.handle;
          count_nxt   = cnt_dec;
          req_c.raddr = cnt_dec[AW-1:0];
        end else begin
          pend_v_nxt = 1'b0;
        end
      end
      dths_pkg::ST_POP_LAST: begin
        me_nxt  = ram_rdata;
        idx_nxt = '0;
      end
      // sift-down
      dths_pkg::ST_DN_START: begin
        if (l_ok) begin
          req_c.raddr = l_w[AW-1:0];
        end else begin
          req_c.we    = 1'b1;
          req_c.waddr = idx_r;
          req_c.wdata = me_r;
        end
      end
      dths_pkg::ST_DN_L: begin
        left_nxt = ram_rdata;
        if (r_ok) begin
          req_c.raddr = r_w[AW-1:0];
        end else begin
          ch_nxt    = ram_rdata;
          chidx_nxt = l_w[AW-1:0];
        end
      end
      dths_pkg::ST_DN_R: begin
        // ties go to the right child
        ch_nxt    = pick_l ? left_r : ram_rdata;
        chidx_nxt = pick_l ? l_w[AW-1:0] : r_w[AW-1:0];
      end
      dths_pkg::ST_DN_CMP: begin
        req_c.we    = 1'b1;
        req_c.waddr = idx_r;
        if (down_move) begin
          req_c.wdata = ch_r;
          idx_nxt     = chidx_r;
        end else begin
          req_c.wdata = me_r;
        end
      end
      default: ;
    endcase
  end

  // the new entry lands at the root once sift-up reaches it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_root_fix_r <= 1'b0;
    end else begin
      up_root_fix_r <= (state_r == dths_pkg::ST_UP_CMP) && up_less && (parent == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= dths_pkg::ST_IDLE;
      tick_r   <= '0;
      count_r  <= '0;
      pend_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tick_r   <= tick_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    dly_r    <= dly_nxt;
    new_r    <= new_nxt;
    me_r     <= me_nxt;
    left_r   <= left_nxt;
    ch_r     <= ch_nxt;
    chidx_r  <= chidx_nxt;
    pend_h_r <= pend_h_nxt;
    ok_r     <= ok_nxt;
    oh_r     <= oh_nxt;
    ot_r     <= ot_nxt;
    ol_r     <= ol_nxt;
  end

  // a root write is pending only in the cycle after sift-up reached it;
  // the block is busy then and issues no other write
  always_comb begin
    req_out = req_c;
    if (up_root_fix_r) begin
      req_out.we    = 1'b1;
      req_out.waddr = '0;
      req_out.wdata = new_r;
    end
  end

  assign ram_req          = req_out;
  assign busy             = (state_r != dths_pkg::ST_IDLE) || up_root_fix_r;
  assign out_valid        = ov_r;
  assign out_kind         = ok_r;
  assign out_fired_handle = oh_r;
  assign out_tick_now     = ot_r;
  assign out_last         = ol_r;
  assign stat.count       = count_r;
  assign stat.tick        = tick_r;
  assign stat.pend_v      = pend_v_r;

endmodule

>>> src/delay_timer_heap_scheduler.sv
// top level of the delay timer heap scheduler
// depends on dths_pkg, dths_ram, dths_ctrl and delay_timer_heap_scheduler_macros.svh
//
// Pulse start with busy low to issue a beat: in_op 1 schedules in_handle to expire
// in_delay ticks from now, in_op 0 advances the tick count by one. Results arrive on
// out_* qualified by out_valid for one cycle each and cannot be held off; out_last
// marks the final result of a beat. A schedule beat answers in the cycle after it is
// taken; a rejected one or one into an empty heap leaves busy low, any other climbs
// the heap one level per ST_UP_CMP step. A tick beat on an empty heap only advances
// the tick count; otherwise it checks the root (ST_TK_ROOT, ST_TK_CHECK) and, per
// expired entry, fetches the last entry (ST_POP_LAST) and sifts it down level by level
// via ST_DN_START, ST_DN_L, ST_DN_R, ST_DN_CMP over the store's single read port.
`include "delay_timer_heap_scheduler_macros.svh"

module delay_timer_heap_scheduler (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_op,
  input  logic [dths_pkg::TICK_W-1:0]       in_delay,
  input  logic [dths_pkg::HANDLE_BITS-1:0]  in_handle,
  output logic                              out_valid,
  output logic [1:0]                        out_kind,
  output logic [dths_pkg::HANDLE_BITS-1:0]  out_fired_handle,
  output logic [dths_pkg::TICK_W-1:0]       out_tick_now,
  output logic                              out_last
);

  dths_pkg::ram_req_t   ram_req;
  dths_pkg::entry_t     ram_rdata;
  dths_pkg::ctrl_stat_t stat;

  // sequencer
  dths_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_delay         (in_delay),
    .in_handle        (in_handle),
    .out_valid        (out_valid),
    .out_kind         (out_kind),
    .out_fired_handle (out_fired_handle),
    .out_tick_now     (out_tick_now),
    .out_last         (out_last),
    .ram_req          (ram_req),
    .ram_rdata        (ram_rdata),
    .stat             (stat)
  );

  // entry store
  dths_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  `DTHS_ASSERT_SAME(a_count_bound, 1'b1, stat.count <= dths_pkg::CNT_W'(dths_pkg::HEAP_DEPTH), "entry count above depth")
  `DTHS_ASSERT_NEXT(a_tick_step, start && !busy && in_op == dths_pkg::OP_TICK, stat.tick == $past(stat.tick) + dths_pkg::TICK_W'(1), "tick beat did not advance count")
  `DTHS_ASSERT_SAME(a_sched_last, out_valid && out_kind != dths_pkg::KIND_EXPIRED, out_last, "schedule answer not marked last")
  `DTHS_ASSERT_SAME(a_idle_clean, !busy, !stat.pend_v, "expired entry held while idle")

endmodule

>>> tb/delay_timer_heap_scheduler_tb.sv
// self-checking testbench of the delay timer heap scheduler
// depends on dths_pkg and delay_timer_heap_scheduler; directed table then random beats
`timescale 1ns / 100ps

module delay_timer_heap_scheduler_tb;
  import dths_pkg::*;

  typedef struct packed {
    logic [1:0]             kind;
    logic [HANDLE_BITS-1:0] hnd;
    logic [TICK_W-1:0]      now;
    logic                   last;
  } res_t;

  typedef struct {
    logic                   op;
    logic [TICK_W-1:0]      delay;
    logic [HANDLE_BITS-1:0] hnd;
    logic                   typed;
    res_t                   res;
  } row_t;

  localparam int WATCHDOG = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_op = 1'b0;
  logic [TICK_W-1:0] in_delay = '0;
  logic [HANDLE_BITS-1:0] in_handle = '0;
  logic out_valid;
  logic [1:0] out_kind;
  logic [HANDLE_BITS-1:0] out_fired_handle;
  logic [TICK_W-1:0] out_tick_now;
  logic out_last;

  // predictor state
  logic [TICK_W-1:0] mdl_tick;
  int unsigned mdl_count;
  logic [TICK_W-1:0] mdl_exp [HEAP_DEPTH];
  logic [HANDLE_BITS-1:0] mdl_hnd [HEAP_DEPTH];

  res_t pending_results [$];
  int errors = 0;
  int idle_cycles = 0;
  row_t dir_rows [$];

  delay_timer_heap_scheduler dut (.*);

  always #10 clk = ~clk;

  // remove root and sift down relative to ref_t
  task automatic heap_pop(input logic [TICK_W-1:0] ref_t);
    int unsigned c, i, l, r, ch;
    logic [TICK_W-1:0] me;
    logic [HANDLE_BITS-1:0] mh;
    c = mdl_count - 1;
    me = mdl_exp[c];
    mh = mdl_hnd[c];
    i = 0;
    mdl_exp[0] = me;
    mdl_hnd[0] = mh;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      if (r < c) ch = ((mdl_exp[l] - ref_t) < (mdl_exp[r] - ref_t)) ? l : r;
      else if (l < c) ch = l;
      else break;
      if ((mdl_exp[ch] - ref_t) < (me - ref_t)) begin
        mdl_exp[i] = mdl_exp[ch];
        mdl_hnd[i] = mdl_hnd[ch];
        mdl_exp[ch] = me;
        mdl_hnd[ch] = mh;
        i = ch;
      end else break;
    end
    mdl_count = c;
  endtask

  // expected results of one beat, appended to the pending queue
  task automatic predict_beat(input logic op, input logic [TICK_W-1:0] dly,
                              input logic [HANDLE_BITS-1:0] h);
    int unsigned i, p, n;
    logic [TICK_W-1:0] ex;
    if (op == OP_SCHED) begin
      if (mdl_count >= HEAP_DEPTH || dly == 0) begin
        pending_results.push_back('{KIND_REJECT, h, mdl_tick, 1'b1});
        return;
      end
      i = mdl_count;
      ex = mdl_tick + dly;
      mdl_exp[i] = ex;
      mdl_hnd[i] = h;
      mdl_count++;
      while (i > 0) begin
        p = (i - 1) / 2;
        if (dly < mdl_exp[p] - mdl_tick) begin
          mdl_exp[i] = mdl_exp[p];
          mdl_hnd[i] = mdl_hnd[p];
          mdl_exp[p] = ex;
          mdl_hnd[p] = h;
          i = p;
        end else break;
      end
      pending_results.push_back('{KIND_ACCEPT, h, mdl_tick, 1'b1});
    end else begin
      n = 0;
      mdl_tick = mdl_tick + 1;
      while (mdl_count > 0 && mdl_exp[0] == mdl_tick && n < HEAP_DEPTH) begin
        pending_results.push_back('{KIND_EXPIRED, mdl_hnd[0], mdl_tick, 1'b0});
        n++;
        heap_pop(mdl_tick);
      end
      if (n > 0) pending_results[$].last = 1'b1;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      res_t got, want;
      got = '{out_kind, out_fired_handle, out_tick_now, out_last};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected kind %0d handle %h tick %h last %b, actual kind %0d handle %h tick %h last %b",
                   $time, want.kind, want.hnd, want.now, want.last,
                   got.kind, got.hnd, got.now, got.last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with nothing accepted or returned
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // issue one beat; typed rows also pin the first expected result
  task automatic send_beat(input logic op, input logic [TICK_W-1:0] dly,
                           input logic [HANDLE_BITS-1:0] h, input bit gaps,
                           input logic typed, input res_t res);
    int qs;
    if (gaps) begin
      while ($urandom_range(99) < 24) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_op <= op;
    in_delay <= dly;
    in_handle <= h;
    do @(posedge clk); while (busy);
    qs = pending_results.size();
    predict_beat(op, dly, h);
    if (typed && pending_results.size() > qs && pending_results[qs] !== res) begin
      $display("%0t: table mismatch expected %h, actual %h", $time, res, pending_results[qs]);
      errors++;
    end
  endtask

  task automatic add_row(input logic op, input logic [TICK_W-1:0] dly,
                         input logic [HANDLE_BITS-1:0] h, input logic typed,
                         input res_t res);
    dir_rows.push_back('{op, dly, h, typed, res});
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_results.size() != 0 && guard < WATCHDOG) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int k, r;
    logic op;
    logic [TICK_W-1:0] dly;
    mdl_tick = '0;
    mdl_count = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: rejects, extremes, zero handle, ties, full heap
    add_row(OP_SCHED, 32'd0, 8'hAA, 1'b1, '{KIND_REJECT, 8'hAA, 32'd0, 1'b1});
    add_row(OP_TICK, 32'd0, 8'h00, 1'b0, '0);
    add_row(OP_SCHED, 32'd1, 8'h00, 1'b1, '{KIND_ACCEPT, 8'h00, 32'd1, 1'b1});
    add_row(OP_TICK, 32'd0, 8'h00, 1'b1, '{KIND_EXPIRED, 8'h00, 32'd2, 1'b1});
    add_row(OP_SCHED, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{KIND_ACCEPT, 8'hFF, 32'd2, 1'b1});
    for (k = 0; k < 7; k++) add_row(OP_SCHED, 32'd2, 8'(k + 1), 1'b0, '0);
    add_row(OP_SCHED, 32'd3, 8'h55, 1'b1, '{KIND_REJECT, 8'h55, 32'd2, 1'b1});
    add_row(OP_TICK, 32'd0, 8'h00, 1'b0, '0);
    add_row(OP_TICK, 32'd0, 8'h00, 1'b0, '0);
    add_row(OP_SCHED, 32'hFFFF_FFFE, 8'h11, 1'b0, '0);
    add_row(OP_SCHED, 32'h8000_0000, 8'h22, 1'b0, '0);
    add_row(OP_SCHED, 32'h5A5A_A5A5, 8'h33, 1'b0, '0);
    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].delay, dir_rows[i].hnd, 1'b0,
                dir_rows[i].typed, dir_rows[i].res);

    // sender holds off until everything has come back
    drain();

    // random beats: short delays so entries expire, a few wide ones
    for (k = 0; k < 330; k++) begin
      r = $urandom_range(99);
      op = (r < 45) ? OP_SCHED : OP_TICK;
      if ($urandom_range(9) == 0) dly = $urandom();
      else if ($urandom_range(19) == 0) dly = 0;
      else dly = $urandom_range(6, 1);
      send_beat(op, dly, 8'($urandom()), (k < 100 || k > 180), 1'b0, '0);
    end

    drain();
    if (errors == 0 && pending_results.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
